// ----- sv/qvr_pkg.sv -----
// shared types, widths and helpers for the quaternion vector rotator
package qvr_pkg;

    localparam int DATA_W = 16;
    localparam int PROD_W = 32;
    localparam int MAT_W = 34;
    localparam int LANE_W = 50;
    localparam int ACC_W = 52;
    localparam int FRAC_BITS = 28;
    localparam int RND_W = ACC_W - FRAC_BITS;
    localparam int NUM_LANES = 3;

    localparam logic signed [MAT_W-1:0] ONE_FX = MAT_W'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [ACC_W-1:0] HALF_FX = ACC_W'(64'sd1 <<< (FRAC_BITS - 1));
    localparam logic signed [RND_W-1:0] SAT_HI = RND_W'(32767);
    localparam logic signed [RND_W-1:0] SAT_LO = RND_W'(-32768);
    localparam logic signed [DATA_W-1:0] OUT_HI = DATA_W'(32767);
    localparam logic signed [DATA_W-1:0] OUT_LO = DATA_W'(-32768);

    typedef struct packed {
        logic signed [DATA_W-1:0] quat_w;
        logic signed [DATA_W-1:0] quat_x;
        logic signed [DATA_W-1:0] quat_y;
        logic signed [DATA_W-1:0] quat_z;
        logic signed [DATA_W-1:0] vec_x;
        logic signed [DATA_W-1:0] vec_y;
        logic signed [DATA_W-1:0] vec_z;
    } sample_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] rot_x;
        logic signed [DATA_W-1:0] rot_y;
        logic signed [DATA_W-1:0] rot_z;
        logic                     saturated;
    } result_word_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] z;
    } vec_t;

    // one matrix row, each entry in units of 2^-28
    typedef struct packed {
        logic signed [MAT_W-1:0] c0;
        logic signed [MAT_W-1:0] c1;
        logic signed [MAT_W-1:0] c2;
    } row_t;

    // exact doubling of a quaternion product into matrix width
    function automatic logic signed [MAT_W-1:0] dbl(input logic signed [PROD_W-1:0] p);
        return $signed({p[PROD_W-1], p, 1'b0});
    endfunction

endpackage

// ----- sv/qvr_matrix.sv -----
// quaternion to rotation matrix, two register stages
module qvr_matrix (
    input  logic           clk,
    input  logic           en,
    input  qvr_pkg::sample_word_t sample,
    output qvr_pkg::row_t  rows [qvr_pkg::NUM_LANES],
    output qvr_pkg::vec_t  vec
);
    import qvr_pkg::*;

    logic signed [PROD_W-1:0] xx_reg, yy_reg, zz_reg;
    logic signed [PROD_W-1:0] xy_reg, xz_reg, yz_reg;
    logic signed [PROD_W-1:0] xw_reg, yw_reg, zw_reg;
    vec_t vec1_reg;
    vec_t vec2_reg;
    row_t rows_reg [NUM_LANES];
    row_t rows_next [NUM_LANES];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xx_reg <= sample.quat_x * sample.quat_x;
            yy_reg <= sample.quat_y * sample.quat_y;
            zz_reg <= sample.quat_z * sample.quat_z;
            xy_reg <= sample.quat_x * sample.quat_y;
            xz_reg <= sample.quat_x * sample.quat_z;
            yz_reg <= sample.quat_y * sample.quat_z;
            xw_reg <= sample.quat_x * sample.quat_w;
            yw_reg <= sample.quat_y * sample.quat_w;
            zw_reg <= sample.quat_z * sample.quat_w;
            vec1_reg <= '{x: sample.vec_x, y: sample.vec_y, z: sample.vec_z};
        end
    end

    always_comb
    begin
        rows_next[0].c0 = ONE_FX - dbl(yy_reg) - dbl(zz_reg);
        rows_next[0].c1 = dbl(xy_reg) - dbl(zw_reg);
        rows_next[0].c2 = dbl(xz_reg) + dbl(yw_reg);
        rows_next[1].c0 = dbl(xy_reg) + dbl(zw_reg);
        rows_next[1].c1 = ONE_FX - dbl(xx_reg) - dbl(zz_reg);
        rows_next[1].c2 = dbl(yz_reg) - dbl(xw_reg);
        rows_next[2].c0 = dbl(xz_reg) - dbl(yw_reg);
        rows_next[2].c1 = dbl(yz_reg) + dbl(xw_reg);
        rows_next[2].c2 = ONE_FX - dbl(xx_reg) - dbl(yy_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rows_reg <= rows_next;
            vec2_reg <= vec1_reg;
        end
    end

    assign rows = rows_reg;
    assign vec = vec2_reg;

endmodule

// ----- sv/qvr_lane.sv -----
// one matrix row times the vector, rounded and saturated
module qvr_lane (
    input  logic                          clk,
    input  logic                          en,
    input  qvr_pkg::row_t                 row,
    input  qvr_pkg::vec_t                 vec,
    output logic signed [qvr_pkg::DATA_W-1:0] rot,
    output logic                          clip
);
    import qvr_pkg::*;

    logic signed [LANE_W-1:0] p0_reg, p1_reg, p2_reg;
    logic signed [ACC_W-1:0]  acc;
    logic signed [RND_W-1:0]  rnd;
    logic signed [DATA_W-1:0] rot_reg, rot_next;
    logic                     clip_reg, clip_next;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg <= row.c0 * vec.x;
            p1_reg <= row.c1 * vec.y;
            p2_reg <= row.c2 * vec.z;
        end
    end

    // round half up is floor of (acc + half)
    always_comb
    begin
        acc = ACC_W'(p0_reg) + ACC_W'(p1_reg) + ACC_W'(p2_reg) + HALF_FX;
        rnd = $signed(acc[ACC_W-1:FRAC_BITS]);
        if (rnd > SAT_HI)
        begin
            rot_next = OUT_HI;
            clip_next = 1'b1;
        end
        else if (rnd < SAT_LO)
        begin
            rot_next = OUT_LO;
            clip_next = 1'b1;
        end
        else
        begin
            rot_next = rnd[DATA_W-1:0];
            clip_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rot_reg <= rot_next;
            clip_reg <= clip_next;
        end
    end

    assign rot = rot_reg;
    assign clip = clip_reg;

endmodule

// ----- sv/quaternion_vector_rotate.sv -----
// throughput: one word per cycle when not stalled; products, matrix, lane products and lane sums
// are four register stages, the three matrix rows run as parallel lanes
// backpressure stalls the whole pipeline, the last stage is the output register
// reset clears the stage valid bits only, data registers are not reset
module quaternion_vector_rotate (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    output logic                  sample_ready,
    input  qvr_pkg::sample_word_t sample_data,
    output logic                  result_valid,
    input  logic                  result_ready,
    output qvr_pkg::result_word_t result_data
);
    import qvr_pkg::*;

    logic en;
    logic [3:0] vld_reg, vld_next;
    row_t rows [NUM_LANES];
    vec_t vec;
    logic signed [DATA_W-1:0] rot [NUM_LANES];
    logic [NUM_LANES-1:0] clip;

    // pipeline moves unless a finished word is waiting
    assign en = !vld_reg[3] || result_ready;
    assign sample_ready = en;
    assign vld_next = {vld_reg[2:0], sample_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    qvr_matrix u_matrix (
        .clk    (clk),
        .en     (en),
        .sample (sample_data),
        .rows   (rows),
        .vec    (vec)
    );

    for (genvar i = 0; i < NUM_LANES; i++)
    begin : g_lane
        qvr_lane u_lane (
            .clk  (clk),
            .en   (en),
            .row  (rows[i]),
            .vec  (vec),
            .rot  (rot[i]),
            .clip (clip[i])
        );
    end

    // merge lane results into the output word
    assign result_valid = vld_reg[3];
    assign result_data.rot_x = rot[0];
    assign result_data.rot_y = rot[1];
    assign result_data.rot_z = rot[2];
    assign result_data.saturated = |clip;

endmodule

// ----- tb/tb_quaternion_vector_rotate.sv -----
// self-checking testbench for the quaternion vector rotator
`timescale 1ns / 100ps

module tb_quaternion_vector_rotate;

    import qvr_pkg::*;

    localparam int     RANDOM_WORDS = 1080;
    localparam int     HOLD_CYCLES  = 200;
    localparam int     HOLD_AFTER   = 300;
    localparam int     DRAIN_CYCLES = 12;
    localparam int     CYCLE_LIMIT  = 200000;
    localparam longint UNITY        = longint'(1) <<< 28;
    localparam longint HALF_LSB     = longint'(1) <<< 27;

    class rotation_scoreboard;
        result_word_t expected_q[$];
        int           words_in;
        int           words_out;
        int           clipped;
        int           errors;

        // exact matrix-vector product in units of 2^-28, rounded half up, then clipped
        function result_word_t rotate(sample_word_t s);
            longint       w, x, y, z;
            longint       v[3];
            longint       m[3][3];
            longint       acc, r;
            bit           clip;
            result_word_t o;
            logic [15:0]  c[3];
            w = longint'($signed(s.quat_w));
            x = longint'($signed(s.quat_x));
            y = longint'($signed(s.quat_y));
            z = longint'($signed(s.quat_z));
            v[0] = longint'($signed(s.vec_x));
            v[1] = longint'($signed(s.vec_y));
            v[2] = longint'($signed(s.vec_z));
            m[0][0] = UNITY - 2 * (y * y) - 2 * (z * z);
            m[0][1] = 2 * (x * y) - 2 * (z * w);
            m[0][2] = 2 * (x * z) + 2 * (y * w);
            m[1][0] = 2 * (x * y) + 2 * (z * w);
            m[1][1] = UNITY - 2 * (x * x) - 2 * (z * z);
            m[1][2] = 2 * (y * z) - 2 * (x * w);
            m[2][0] = 2 * (x * z) - 2 * (y * w);
            m[2][1] = 2 * (y * z) + 2 * (x * w);
            m[2][2] = UNITY - 2 * (x * x) - 2 * (y * y);
            clip = 1'b0;
            for (int i = 0; i < 3; i++)
            begin
                acc = m[i][0] * v[0] + m[i][1] * v[1] + m[i][2] * v[2];
                r = (acc + HALF_LSB) >>> 28;
                if (r > 32767)
                begin
                    r = 32767;
                    clip = 1'b1;
                end
                else if (r < -32768)
                begin
                    r = -32768;
                    clip = 1'b1;
                end
                c[i] = 16'(r);
            end
            o.rot_x = c[0];
            o.rot_y = c[1];
            o.rot_z = c[2];
            o.saturated = clip;
            return o;
        endfunction

        function void note_sample(sample_word_t s);
            expected_q.push_back(rotate(s));
            words_in++;
        endfunction

        function bit field_ok(string name, logic [15:0] e, logic [15:0] a);
            if (a === e)
                return 1'b1;
            $display("%0t: %s mismatch, expected %0d got %0d",
                     $time, name, $signed(e), $signed(a));
            return 1'b0;
        endfunction

        function void check_result(result_word_t r);
            result_word_t e;
            bit           ok;
            if (expected_q.size() == 0)
            begin
                $display("%0t: result word with nothing expected, expected none got %h",
                         $time, r);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            words_out++;
            if (e.saturated)
                clipped++;
            ok = field_ok("rot_x", e.rot_x, r.rot_x);
            ok = field_ok("rot_y", e.rot_y, r.rot_y) && ok;
            ok = field_ok("rot_z", e.rot_z, r.rot_z) && ok;
            ok = field_ok("saturated", 16'(e.saturated), 16'(r.saturated)) && ok;
            if (!ok)
                errors++;
        endfunction
    endclass

    logic         clk = 1'b0;
    logic         rst_n;
    logic         sample_valid;
    logic         sample_ready;
    sample_word_t sample_data;
    logic         result_valid;
    logic         result_ready;
    result_word_t result_data;

    rotation_scoreboard sb;
    int                 cycles = 0;
    int                 burst_left = 0;
    int                 held_cycles = 0;
    int                 directed_words = 0;

    quaternion_vector_rotate dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample_data  (sample_data),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_data  (result_data)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            sb.check_result(result_data);
    end

    function automatic sample_word_t mk(int w, int x, int y, int z, int vx, int vy, int vz);
        sample_word_t s;
        s.quat_w = 16'(w);
        s.quat_x = 16'(x);
        s.quat_y = 16'(y);
        s.quat_z = 16'(z);
        s.vec_x = 16'(vx);
        s.vec_y = 16'(vy);
        s.vec_z = 16'(vz);
        return s;
    endfunction

    function automatic logic [15:0] to_q14(real r);
        int k;
        k = $rtoi(r * 16384.0);
        if (k > 32767)
            k = 32767;
        if (k < -32768)
            k = -32768;
        return 16'(k);
    endfunction

    function automatic logic [15:0] edge_or_random();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'hffff;
            2: return 16'h0000;
            3: return 16'h0001;
            4: return 16'h7fff;
            default: return 16'($urandom);
        endcase
    endfunction

    // unit quaternion from four random components, some stretched, or edge, small or raw
    function automatic sample_word_t random_sample();
        sample_word_t s;
        real          a, b, c, d, n, k;
        int           kind;
        int           span;
        kind = $urandom_range(0, 9);
        s = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        if (kind <= 3 || kind == 7 || kind == 9)
        begin
            a = $itor($signed(16'($urandom)));
            b = $itor($signed(16'($urandom)));
            c = $itor($signed(16'($urandom)));
            d = $itor($signed(16'($urandom)));
            n = $sqrt(a * a + b * b + c * c + d * d);
            if (n < 1.0)
            begin
                a = 1.0;
                n = 1.0;
            end
            k = (kind == 7) ? 1.0 + $itor($urandom_range(0, 1000)) / 1000.0 : 1.0;
            s.quat_w = to_q14(a / n * k);
            s.quat_x = to_q14(b / n * k);
            s.quat_y = to_q14(c / n * k);
            s.quat_z = to_q14(d / n * k);
            if (kind == 9)
            begin
                s.vec_x = 16'($urandom_range(0, 510) - 255);
                s.vec_y = 16'($urandom_range(0, 510) - 255);
                s.vec_z = 16'($urandom_range(0, 510) - 255);
            end
        end
        else if (kind == 6)
        begin
            span = $urandom_range(1, 2048);
            s.quat_w = 16'($urandom_range(0, 2 * span) - span);
            s.quat_x = 16'($urandom_range(0, 2 * span) - span);
            s.quat_y = 16'($urandom_range(0, 2 * span) - span);
            s.quat_z = 16'($urandom_range(0, 2 * span) - span);
        end
        else if (kind == 8)
        begin
            s.quat_w = edge_or_random();
            s.quat_x = edge_or_random();
            s.quat_y = edge_or_random();
            s.quat_z = edge_or_random();
            s.vec_x = edge_or_random();
            s.vec_y = edge_or_random();
            s.vec_z = edge_or_random();
        end
        return s;
    endfunction

    task automatic send_word(input sample_word_t s);
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 16);
            if ($urandom_range(0, 3) != 0)
            begin
                sample_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
        sample_valid <= 1'b1;
        sample_data <= s;
        do
            @(posedge clk);
        while (!sample_ready);
        sb.note_sample(s);
        burst_left--;
    endtask

    // receiver: cycles through four stall patterns, plus one long hold-off
    initial
    begin
        int  cyc;
        int  stall;
        bit  rdy;
        bit  held;
        result_ready <= 1'b0;
        cyc = 0;
        stall = 0;
        held = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!held && sb.words_in >= HOLD_AFTER)
            begin
                held = 1'b1;
                result_ready <= 1'b0;
                for (int i = 0; i < HOLD_CYCLES; i++)
                begin
                    @(posedge clk);
                    held_cycles++;
                end
            end
            case ((cyc / 150) % 4)
                0: rdy = 1'b1;
                1: rdy = 1'($urandom_range(0, 1));
                2: rdy = (cyc % 3) != 0;
                default:
                begin
                    if (stall > 0)
                    begin
                        stall--;
                        rdy = 1'b0;
                    end
                    else if ($urandom_range(0, 9) == 0)
                    begin
                        stall = $urandom_range(1, 8);
                        rdy = 1'b0;
                    end
                    else
                        rdy = 1'b1;
                end
            endcase
            result_ready <= rdy;
            cyc++;
            @(posedge clk);
        end
    end

    initial
    begin
        sample_word_t directed[$];
        sb = new();
        rst_n <= 1'b0;
        sample_valid <= 1'b0;
        sample_data <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identity, zero quaternion (still identity matrix), quarter and half turns
        directed.push_back(mk(16384, 0, 0, 0, 32767, -32768, 12345));
        directed.push_back(mk(16384, 0, 0, 0, -32768, 32767, 0));
        directed.push_back(mk(0, 0, 0, 0, 1000, -1000, 500));
        directed.push_back(mk(11585, 0, 0, 11585, 1000, 0, 0));
        directed.push_back(mk(11585, 11585, 0, 0, 0, 1000, 0));
        // quarter turn about y exercises the top-right matrix entry
        directed.push_back(mk(11585, 0, 11585, 0, 0, 0, 1000));
        directed.push_back(mk(0, 16384, 0, 0, 100, 200, 300));
        directed.push_back(mk(0, 0, 0, 16384, -32768, -32768, -32768));
        directed.push_back(mk(0, 0, 16384, 0, 32767, 0, -32768));
        // exact half-unit results: +0.5 rounds up, -0.5 rounds toward zero
        directed.push_back(mk(0, 8192, 8192, 0, 0, 1, 0));
        directed.push_back(mk(0, 8192, 8192, 0, 0, -1, 0));
        directed.push_back(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767));
        directed.push_back(mk(-32768, -32768, -32768, -32768, -32768, -32768, -32768));
        directed.push_back(mk(-32768, 0, 0, 0, 32767, 32767, 32767));
        directed.push_back(mk(0, -32768, 0, 0, 1, 1, 1));
        directed.push_back(mk(32767, 0, 0, -32768, 20000, -20000, 0));
        directed.push_back(mk(16384, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk(-16384, 0, 0, 0, 7, -7, 1));
        directed.push_back(mk(8192, 8192, 8192, 8192, 1234, -4321, 999));
        directed.push_back(mk(1, -1, 1, -1, -32768, 32767, -32768));
        directed.push_back(mk(32767, -32768, 32767, -32768, 0, 0, 0));

        foreach (directed[i])
            send_word(directed[i]);
        directed_words = directed.size();
        for (int i = 0; i < RANDOM_WORDS; i++)
            send_word(random_sample());
        sample_valid <= 1'b0;

        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d sample words (%0d directed), checked %0d results, %0d clipped",
                 sb.words_in, directed_words, sb.words_out, sb.clipped);
        $display("output held off for %0d cycles under load, %0d word errors",
                 held_cycles, sb.errors);
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
